// ----- src/tbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

  localparam int COLUMNS    = 52;
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int MEAN_W = COUNT_BITS + FRAC_BITS;
  localparam int N_W    = 5;
  localparam int PROD_W = MEAN_W + N_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DVS_W  = N_W + 1;
  localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int DCNT_W = $clog2(NUM_W);

  localparam int COL_W      = 6;
  localparam int HIT_W      = 16;
  localparam int TRIM_W     = 5;
  localparam int FIN_W      = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int RISE_W     = 4;

  localparam logic [TRIM_W-1:0] TRIM_TOP   = 5'd15;
  localparam logic [TRIM_W-1:0] BP_START   = 5'h1f;
  localparam logic [2:0]        STEP_START = 3'd4;
  localparam logic [2:0]        STEP_HALF  = 3'd2;
  localparam logic [2:0]        STEP_ONE   = 3'd1;
  localparam logic [N_W-1:0]    N_MAX      = 5'd31;
  localparam logic [RISE_W-1:0] RISE_RESET = 4'd3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_COUNT = 1'b1;

  // Register index as seen in paddr[2]; the two low address bits are not decoded.
  localparam logic REG_RISE = 1'b0;

  typedef struct packed {
    logic [TRIM_W-1:0] trim;
    logic [2:0]        step;
    logic [TRIM_W-1:0] bp;
    logic [MEAN_W-1:0] mean;
    logic [N_W-1:0]    n;
  } tbs_entry_t;

  localparam tbs_entry_t ENTRY_RESET = '{
    trim: TRIM_TOP,
    step: STEP_START,
    bp:   BP_START,
    mean: '0,
    n:    '0
  };

endpackage

`default_nettype wire

// ----- src/trim_breakdown_search_top.sv -----
// Flow: a start or an out-of-range transaction goes from S_IDLE to S_FIN, where its result is
// loaded once the output is free; a finished-column count passes S_LOAD, and a reference or
// breakdown count S_LOAD and S_TEST, before S_FIN; a count joining the mean passes S_LOAD,
// S_TEST, S_ADD and S_DIV. The mean update runs a restoring divider, 30 quotient bits.
// One transaction is in flight at a time; s_axis_tready rises at the edge that loads the result.
// Reset is asynchronous and active low; every column then reads as freshly started and
// rise_factor is 3. The column store needs no clearing pass, valid bits mark written rows.
`timescale 1ns / 1ps
`default_nettype none

module trim_breakdown_search_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [5:0] column_index, [21:6] hit_count, [23:22] zero
  input  wire logic [tbs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [0] req_type
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [5:0] column_out, [10:6] next_trim, [11] column_done, [15:12] final_trim,
  // [16] ignored, [23:17] zero
  output logic [tbs_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tbs_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [tbs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [tbs_pkg::APB_DATA_W-1:0]           prdata,
  output logic                                     pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_TEST,
    S_ADD,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q;

  logic [tbs_pkg::RISE_W-1:0] rise_q;

  logic [tbs_pkg::COL_W-1:0]      col_q;
  logic [tbs_pkg::CIDX_W-1:0]     row_q;
  logic [tbs_pkg::MEAN_W-1:0]     scaled_q;
  logic                           oor_q;
  logic                           ign_q;
  logic                           we_q;
  tbs_pkg::tbs_entry_t            new_q;
  logic [tbs_pkg::PROD_W-1:0]     prod_q;
  logic [tbs_pkg::NUM_W-1:0]      num_q;
  logic [tbs_pkg::DVS_W-1:0]      rem_q;
  logic [tbs_pkg::DVS_W-1:0]      dvs_q;
  logic [tbs_pkg::DCNT_W-1:0]     dcnt_q;
  logic                           m_valid_q;
  logic [tbs_pkg::OUT_DATA_W-1:0] m_data_q;

  tbs_pkg::tbs_entry_t mem [tbs_pkg::COLUMNS];
  tbs_pkg::tbs_entry_t rd_q;
  logic [tbs_pkg::COLUMNS-1:0] vld_q;
  logic                        vld_rd_q;

  logic [tbs_pkg::COL_W-1:0]  in_col;
  logic [tbs_pkg::HIT_W-1:0]  in_hit;
  logic                       in_oor;
  logic                       accept;
  logic [tbs_pkg::CIDX_W-1:0] in_row;
  logic                       out_free;
  logic                       mem_we;

  tbs_pkg::tbs_entry_t        ent;
  logic                       ent_done;
  logic [tbs_pkg::N_W-1:0]    mul_a;
  logic [tbs_pkg::PROD_W-1:0] prod;
  logic                       brk;
  logic                       upd_path;
  tbs_pkg::tbs_entry_t        upd;
  logic signed [6:0]          trim7;
  logic signed [6:0]          bp7;
  logic signed [6:0]          t7;
  logic [tbs_pkg::N_W-1:0]    nsat;

  logic [tbs_pkg::DVS_W-1:0] trial;
  logic                      qbit;
  logic [tbs_pkg::NUM_W-1:0] num_next;

  logic                        fin_done;
  logic [tbs_pkg::FIN_W-1:0]   fin_val;
  logic [tbs_pkg::TRIM_W-1:0]  out_next;
  logic [tbs_pkg::FIN_W-1:0]   out_fin;
  logic [tbs_pkg::OUT_DATA_W-1:0] out_data;

  assign in_col = s_axis_tdata[tbs_pkg::COL_W-1:0];
  assign in_hit = s_axis_tdata[tbs_pkg::COL_W +: tbs_pkg::HIT_W];
  assign in_oor = !(32'(in_col) < tbs_pkg::COLUMNS);
  assign in_row = tbs_pkg::CIDX_W'(in_col);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign mem_we        = (state_q == S_FIN) && out_free && we_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tbs_pkg::REG_RISE) ? tbs_pkg::APB_DATA_W'(rise_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= tbs_pkg::RISE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == tbs_pkg::REG_RISE)) begin
      rise_q <= pwdata[tbs_pkg::RISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[row_q] <= new_q;
    end
    if (accept && !in_oor) begin
      rd_q <= mem[in_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[row_q] <= 1'b1;
      end
      if (accept && !in_oor) begin
        vld_rd_q <= vld_q[in_row];
      end
    end
  end

  assign ent      = vld_rd_q ? rd_q : tbs_pkg::ENTRY_RESET;
  assign ent_done = $signed(ent.trim) <= $signed(ent.bp);

  assign mul_a = (state_q == S_LOAD) ? tbs_pkg::N_W'(rise_q) : ent.n;
  assign prod  = tbs_pkg::PROD_W'(mul_a) * tbs_pkg::PROD_W'(ent.mean);
  assign brk   = tbs_pkg::PROD_W'(scaled_q) > prod_q;

  always_comb begin
    upd      = ent;
    upd_path = 1'b0;
    trim7    = 7'(signed'(ent.trim));
    bp7      = 7'(signed'(ent.bp));
    nsat     = (ent.n == tbs_pkg::N_MAX) ? ent.n : ent.n + 1'b1;
    t7       = trim7;
    if (ent.trim == tbs_pkg::TRIM_TOP) begin
      upd.mean = scaled_q;
      upd.n    = nsat;
      t7       = trim7 - $signed({4'b0, ent.step});
    end else if (brk) begin
      upd.bp = ent.trim;
      case (ent.step)
        tbs_pkg::STEP_START: begin
          t7       = trim7 + 7'sd2;
          upd.step = tbs_pkg::STEP_HALF;
        end
        tbs_pkg::STEP_HALF: begin
          t7       = trim7 + 7'sd1;
          upd.step = tbs_pkg::STEP_ONE;
        end
        default: begin
          t7       = trim7 - 7'sd1;
          upd.step = tbs_pkg::STEP_ONE;
        end
      endcase
    end else begin
      upd_path = 1'b1;
      if (upd.step == tbs_pkg::STEP_START && trim7 - 7'sd4 <= bp7) begin
        upd.step = tbs_pkg::STEP_HALF;
      end
      if (upd.step == tbs_pkg::STEP_HALF && trim7 - 7'sd2 <= bp7) begin
        upd.step = tbs_pkg::STEP_ONE;
      end
      t7    = trim7 - $signed({4'b0, upd.step});
      upd.n = nsat;
    end
    upd.trim = t7[tbs_pkg::TRIM_W-1:0];
  end

  assign trial    = {rem_q[tbs_pkg::DVS_W-2:0], num_q[tbs_pkg::NUM_W-1]};
  assign qbit     = trial >= dvs_q;
  assign num_next = {num_q[tbs_pkg::NUM_W-2:0], qbit};

  always_comb begin
    fin_done = $signed(new_q.trim) <= $signed(new_q.bp);
    fin_val  = tbs_pkg::FIN_W'(new_q.bp + 1'b1);
    out_next = fin_done ? tbs_pkg::TRIM_W'(fin_val) : new_q.trim;
    out_fin  = fin_done ? fin_val : '0;
    if (oor_q) begin
      out_data = tbs_pkg::OUT_DATA_W'({1'b1, 4'b0, 1'b0, 5'b0, col_q});
    end else begin
      out_data = tbs_pkg::OUT_DATA_W'({ign_q, out_fin, fin_done, out_next, col_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      scaled_q  <= '0;
      oor_q     <= 1'b0;
      ign_q     <= 1'b0;
      we_q      <= 1'b0;
      new_q     <= tbs_pkg::ENTRY_RESET;
      prod_q    <= '0;
      num_q     <= '0;
      rem_q     <= '0;
      dvs_q     <= '0;
      dcnt_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            col_q    <= in_col;
            row_q    <= in_row;
            scaled_q <= tbs_pkg::MEAN_W'(tbs_pkg::COUNT_BITS'(in_hit)) << tbs_pkg::FRAC_BITS;
            oor_q    <= in_oor;
            if (in_oor) begin
              ign_q   <= 1'b1;
              we_q    <= 1'b0;
              state_q <= S_FIN;
            end else if (s_axis_tuser == tbs_pkg::REQ_START) begin
              ign_q   <= 1'b0;
              we_q    <= 1'b1;
              new_q   <= tbs_pkg::ENTRY_RESET;
              state_q <= S_FIN;
            end else begin
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (ent_done) begin
            new_q   <= ent;
            ign_q   <= 1'b1;
            we_q    <= 1'b0;
            state_q <= S_FIN;
          end else begin
            prod_q  <= prod;
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          new_q <= upd;
          ign_q <= 1'b0;
          we_q  <= 1'b1;
          if (upd_path) begin
            prod_q  <= prod;
            state_q <= S_ADD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_ADD: begin
          num_q   <= tbs_pkg::NUM_W'(scaled_q) + tbs_pkg::NUM_W'(prod_q);
          rem_q   <= '0;
          dvs_q   <= tbs_pkg::DVS_W'(ent.n) + 1'b1;
          dcnt_q  <= tbs_pkg::DCNT_W'(tbs_pkg::NUM_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          num_q  <= num_next;
          rem_q  <= qbit ? trial - dvs_q : trial;
          dcnt_q <= dcnt_q - 1'b1;
          if (dcnt_q == '0) begin
            new_q.mean <= num_next[tbs_pkg::MEAN_W-1:0];
            state_q    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= out_data;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction did not leave idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (!oor_q && !ign_q))
    else $error("column store written for an ignored transaction");

endmodule

`default_nettype wire
